// ===== rtl/fnv1_segment_distributor_defines.svh =====
// assertion macros for the fnv1 segment distributor
`ifndef FNV1_SEGMENT_DISTRIBUTOR_DEFINES_SVH
`define FNV1_SEGMENT_DISTRIBUTOR_DEFINES_SVH

// condition implies consequence in the same cycle
`define FNVSD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define FNVSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/fnvsd_pkg.sv =====
// shared types, constants and the fnv step for the fnv1 segment distributor
`default_nettype none

package fnvsd_pkg;

    localparam logic [31:0] FNV_BASIS = 32'h811c_9dc5;
    localparam logic [31:0] NULL_WORD = 32'hF0F0_F0F1;

    localparam int MAX_SEGMENTS_DEF = 4096;
    localparam int SEG_COUNT_W      = 13;
    localparam int SEGMENT_W        = 12;
    localparam int HASH_W           = 32;
    localparam int IN_TDATA_W       = 8;
    localparam int IN_TUSER_W       = 3;
    localparam int OUT_TDATA_W      = 48;
    localparam int CFG_INDEX_W      = 2;
    localparam int CFG_DATA_W       = 32;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_NULL  = 2'd1;
    localparam logic [1:0] KIND_NOKEY = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_SEG_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RR_SEED   = 2'd1;

    typedef struct packed {
        logic              valid;
        logic [HASH_W-1:0] hash;
    } fnvsd_hash_req_t;

    // multiply by 0x01000193 modulo 2^32, then xor in the byte
    function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] prod;
        prod = (h << 24) + (h << 8) + (h << 7) + (h << 4) + (h << 1) + h;
        return prod ^ {24'd0, b};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/fnvsd_front.sv =====
// front end: accepts items while the queue has room and runs the fnv-1 hash, one byte per cycle
`default_nettype none

module fnvsd_front
    import fnvsd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [HASH_W-1:0]     rr_seed,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_TDATA_W-1:0] s_tdata,
    input  wire logic [IN_TUSER_W-1:0] s_tuser,
    input  wire logic                  s_tlast,
    input  wire logic                  q_room,
    output fnvsd_hash_req_t            push
);

    typedef enum logic [1:0] {
        FE_IDLE = 2'b01,
        FE_WORD = 2'b10
    } fe_state_t;

    fe_state_t         state_reg, state_next;
    logic [HASH_W-1:0] hash_reg, hash_next;
    logic [HASH_W-1:0] rr_count_reg, rr_count_next;
    logic [31:0]       word_reg, word_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic              last_reg, last_next;
    logic [HASH_W-1:0] base;
    logic [31:0]       rr_word;
    logic [1:0]        kind;
    logic              accept;

    assign kind     = s_tuser[1:0];
    assign base     = s_tuser[2] ? FNV_BASIS : hash_reg;
    assign rr_word  = rr_seed + rr_count_reg;
    assign s_tready = (state_reg == FE_IDLE) && q_room;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next    = state_reg;
        hash_next     = hash_reg;
        rr_count_next = rr_count_reg;
        word_next     = word_reg;
        cnt_next      = cnt_reg;
        last_next     = last_reg;
        push.valid    = 1'b0;
        unique case (state_reg)
            FE_IDLE:
            begin
                if (accept)
                begin
                    case (kind)
                        KIND_BYTE:
                        begin
                            hash_next  = fnv_step(base, s_tdata);
                            push.valid = s_tlast;
                        end
                        KIND_NULL:
                        begin
                            hash_next  = fnv_step(base, NULL_WORD[7:0]);
                            word_next  = NULL_WORD;
                            cnt_next   = 2'd1;
                            last_next  = s_tlast;
                            state_next = FE_WORD;
                        end
                        KIND_NOKEY:
                        begin
                            hash_next     = fnv_step(base, rr_word[7:0]);
                            word_next     = rr_word;
                            rr_count_next = rr_count_reg + 32'd1;
                            cnt_next      = 2'd1;
                            last_next     = s_tlast;
                            state_next    = FE_WORD;
                        end
                        default:
                        begin
                            hash_next  = base;
                            push.valid = s_tlast;
                        end
                    endcase
                end
            end
            FE_WORD:
            begin
                hash_next = fnv_step(hash_reg, word_reg[{cnt_reg, 3'b000} +: 8]);
                cnt_next  = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    state_next = FE_IDLE;
                    push.valid = last_reg;
                end
            end
            default:
            begin
                state_next = FE_IDLE;
            end
        endcase
        push.hash = hash_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= FE_IDLE;
            hash_reg     <= FNV_BASIS;
            rr_count_reg <= '0;
            cnt_reg      <= '0;
            last_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            hash_reg     <= hash_next;
            rr_count_reg <= rr_count_next;
            cnt_reg      <= cnt_next;
            last_reg     <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

endmodule

`default_nettype wire

// ===== rtl/fnvsd_queue.sv =====
// short queue of finished row hashes between front and back
`default_nettype none

`include "fnv1_segment_distributor_defines.svh"

module fnvsd_queue
    import fnvsd_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire fnvsd_hash_req_t push,
    output logic                 room,
    output fnvsd_hash_req_t      head,
    input  wire logic            pop
);

    logic [HASH_W-1:0] mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign room       = count_reg < QCNT_W'(QUEUE_DEPTH);
    assign head.valid = count_reg != '0;
    assign head.hash  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + QPTR_W'(1);
        end
        if (push.valid && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push.valid)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem_reg[wr_ptr_reg] <= push.hash;
        end
    end

    `FNVSD_ASSERT_NOW(a_no_overflow, push.valid && !pop,
        count_reg < QCNT_W'(QUEUE_DEPTH), "hash queue overflow")
    `FNVSD_ASSERT_NOW(a_no_underflow, pop, count_reg != '0, "hash queue underflow")

endmodule

`default_nettype wire

// ===== rtl/fnvsd_back.sv =====
// back end: reduces a row hash to a segment and holds the result for the receiver
`default_nettype none

`include "fnv1_segment_distributor_defines.svh"

module fnvsd_back
    import fnvsd_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [SEG_COUNT_W-1:0] seg_count,
    input  wire fnvsd_hash_req_t        head,
    output logic                        pop,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata
);

    typedef enum logic [2:0] {
        BK_IDLE = 3'b001,
        BK_DIV  = 3'b010,
        BK_HOLD = 3'b100
    } bk_state_t;

    bk_state_t              state_reg, state_next;
    logic [SEG_COUNT_W-1:0] n_eff;
    logic [SEG_COUNT_W-1:0] n_minus1;
    logic                   pow2;
    logic [SEG_COUNT_W-1:0] rem_reg, rem_next;
    logic [HASH_W-1:0]      dividend_reg, dividend_next;
    logic [4:0]             cnt_reg, cnt_next;
    logic [SEGMENT_W-1:0]   seg_reg, seg_next;
    logic [HASH_W-1:0]      hash_reg, hash_next;
    logic [SEG_COUNT_W:0]   trial;
    logic [SEG_COUNT_W:0]   diff;
    logic [SEG_COUNT_W-1:0] rem_step;

    // clamp the segment count to 1..max
    always_comb
    begin
        if (seg_count == '0)
        begin
            n_eff = SEG_COUNT_W'(1);
        end
        else if ({19'd0, seg_count} > 32'(MAX_SEGMENTS))
        begin
            n_eff = SEG_COUNT_W'(MAX_SEGMENTS);
        end
        else
        begin
            n_eff = seg_count;
        end
    end

    assign n_minus1 = n_eff - SEG_COUNT_W'(1);
    assign pow2     = (n_eff & n_minus1) == '0;

    // one restoring remainder step per cycle
    assign trial    = {rem_reg, dividend_reg[HASH_W-1]};
    assign diff     = trial - {1'b0, n_eff};
    assign rem_step = (trial >= {1'b0, n_eff}) ? diff[SEG_COUNT_W-1:0]
                                              : trial[SEG_COUNT_W-1:0];

    assign pop      = (state_reg == BK_IDLE) && head.valid;
    assign m_tvalid = (state_reg == BK_HOLD);
    assign m_tdata  = {{(OUT_TDATA_W - HASH_W - SEGMENT_W){1'b0}}, hash_reg, seg_reg};

    always_comb
    begin
        state_next    = state_reg;
        rem_next      = rem_reg;
        dividend_next = dividend_reg;
        cnt_next      = cnt_reg;
        seg_next      = seg_reg;
        hash_next     = hash_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (head.valid)
                begin
                    hash_next = head.hash;
                    if (pow2)
                    begin
                        seg_next   = head.hash[SEGMENT_W-1:0] & n_minus1[SEGMENT_W-1:0];
                        state_next = BK_HOLD;
                    end
                    else
                    begin
                        rem_next      = '0;
                        dividend_next = head.hash;
                        cnt_next      = '0;
                        state_next    = BK_DIV;
                    end
                end
            end
            BK_DIV:
            begin
                rem_next      = rem_step;
                dividend_next = {dividend_reg[HASH_W-2:0], 1'b0};
                cnt_next      = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    seg_next   = rem_step[SEGMENT_W-1:0];
                    state_next = BK_HOLD;
                end
            end
            BK_HOLD:
            begin
                if (m_tready)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        dividend_reg <= dividend_next;
        seg_reg      <= seg_next;
        hash_reg     <= hash_next;
    end

    `FNVSD_ASSERT_NOW(a_rem_in_range, state_reg == BK_DIV && cnt_reg != 5'd0,
        rem_reg < n_eff, "remainder not below segment count")
    `FNVSD_ASSERT_NOW(a_seg_in_range, m_tvalid,
        {1'b0, seg_reg} < n_eff, "segment not below segment count")
    `FNVSD_ASSERT_NEXT(a_pop_takes_hash, pop, hash_reg == $past(head.hash),
        "popped hash not captured")

endmodule

`default_nettype wire

// ===== rtl/fnv1_segment_distributor.sv =====
// top level of the fnv1 segment distributor
//
// s_* carries key items: tdata is the key byte, tuser the kind and a row start
// flag, tlast closes a row. a byte item is hashed as it is accepted; a null
// attribute or a no-key row marker hashes a 32-bit word at one byte per cycle.
// each row's hash goes through a two-entry queue to the segment unit, which
// masks the low hash bits when the segment count is a power of two and runs a
// bit-serial remainder loop otherwise. m_* carries one result per row, which the
// segment unit registers straight from the queue head for power-of-two counts
// and after the remainder loop otherwise.
// while the receiver stalls, the result holds on m_* and the front end keeps
// hashing until the queue is full, then drops s_tready.
// cfg_* writes the segment count (index 0) and the no-key seed (index 1); it is
// always ready. the user must write only while the block is idle, which the
// block does not enforce. reset loads the offset basis into the hash, clears
// the no-key count, sets the segment count to one and the seed to zero.
`default_nettype none

module fnv1_segment_distributor
    import fnvsd_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,  // data_byte
    input  wire logic [IN_TUSER_W-1:0]  s_tuser,  // kind[1:0], first[2]
    input  wire logic                   s_tlast,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,  // segment[11:0], hash_out[43:12], zero
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [SEG_COUNT_W-1:0] seg_count_reg;
    logic [HASH_W-1:0]      rr_seed_reg;
    fnvsd_hash_req_t        push;
    fnvsd_hash_req_t        head;
    logic                   q_room;
    logic                   pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_count_reg <= SEG_COUNT_W'(1);
            rr_seed_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SEG_COUNT: seg_count_reg <= cfg_data[SEG_COUNT_W-1:0];
                CFG_RR_SEED:   rr_seed_reg   <= cfg_data[HASH_W-1:0];
                default:       ;
            endcase
        end
    end

    fnvsd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rr_seed  (rr_seed_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_room   (q_room),
        .push     (push)
    );

    fnvsd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .room  (q_room),
        .head  (head),
        .pop   (pop)
    );

    fnvsd_back #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .seg_count (seg_count_reg),
        .head      (head),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire
